// ----- design/utf8d_pkg.sv -----
package utf8d_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [30:0] code_point;
		status_t     status;
		logic [2:0]  sequence_length;
	} out_item_t;

	// open sequence state, all zero when idle
	typedef struct packed {
		logic [2:0]  bytes_pending;
		logic [2:0]  total_length;
		logic [7:0]  lead_byte;
		logic [30:0] partial_value;
	} dec_state_t;

	localparam logic [7:0] LEAD_MIN   = 8'hc2;
	localparam logic [7:0] LEAD_3B    = 8'he0;
	localparam logic [7:0] LEAD_4B    = 8'hf0;
	localparam logic [7:0] LEAD_5B    = 8'hf8;
	localparam logic [7:0] LEAD_6B    = 8'hfc;
	localparam logic [7:0] LEAD_BAD   = 8'hfe;
	localparam logic [7:0] ASCII_END  = 8'h80;

	// overlong limits, checked on the second byte
	localparam logic [7:0] OVL_LEAD_3 = 8'he1;
	localparam logic [7:0] OVL_MIN_3  = 8'ha0;
	localparam logic [7:0] OVL_LEAD_4 = 8'hf1;
	localparam logic [7:0] OVL_MIN_4  = 8'h90;
	localparam logic [7:0] OVL_LEAD_5 = 8'hf9;
	localparam logic [7:0] OVL_MIN_5  = 8'h88;
	localparam logic [7:0] OVL_LEAD_6 = 8'hfd;
	localparam logic [7:0] OVL_MIN_6  = 8'h84;

	localparam dec_state_t IDLE_STATE = '0;

endpackage

// ----- design/utf8d_decode.sv -----
module utf8d_decode (
	input  utf8d_pkg::dec_state_t state,
	input  utf8d_pkg::in_item_t   item,
	output utf8d_pkg::dec_state_t next_state,
	output logic                  emit,
	output utf8d_pkg::out_item_t  result
);

	logic [7:0]  b;
	logic        last;
	logic [2:0]  len;
	logic [30:0] bits;
	logic [2:0]  consumed;
	logic        bad;
	logic        first_cont;
	logic [30:0] new_partial;
	logic [2:0]  new_pending;

	assign b           = item.byte_value;
	assign last        = item.end_of_text;
	assign consumed    = state.total_length - state.bytes_pending + 3'd1;
	assign first_cont  = (state.bytes_pending + 3'd1) == state.total_length;
	assign new_partial = {state.partial_value[24:0], b[5:0]};
	assign new_pending = state.bytes_pending - 3'd1;

	// lead byte length and payload bits
	always_comb begin
		if (b < utf8d_pkg::LEAD_3B) begin
			len  = 3'd2;
			bits = {26'd0, b[4:0]};
		end else if (b < utf8d_pkg::LEAD_4B) begin
			len  = 3'd3;
			bits = {27'd0, b[3:0]};
		end else if (b < utf8d_pkg::LEAD_5B) begin
			len  = 3'd4;
			bits = {28'd0, b[2:0]};
		end else if (b < utf8d_pkg::LEAD_6B) begin
			len  = 3'd5;
			bits = {29'd0, b[1:0]};
		end else begin
			len  = 3'd6;
			bits = {30'd0, b[0]};
		end
	end

	// continuation check including overlong forms
	always_comb begin
		bad = (b[7:6] != 2'b10);
		if (!bad && first_cont) begin
			case (state.total_length)
				3'd3: bad = (state.lead_byte < utf8d_pkg::OVL_LEAD_3) &&
					(b < utf8d_pkg::OVL_MIN_3);
				3'd4: bad = (state.lead_byte < utf8d_pkg::OVL_LEAD_4) &&
					(b < utf8d_pkg::OVL_MIN_4);
				3'd5: bad = (state.lead_byte < utf8d_pkg::OVL_LEAD_5) &&
					(b < utf8d_pkg::OVL_MIN_5);
				3'd6: bad = (state.lead_byte < utf8d_pkg::OVL_LEAD_6) &&
					(b < utf8d_pkg::OVL_MIN_6);
				default: bad = 1'b0;
			endcase
		end
	end

	always_comb begin
		next_state = state;
		emit       = 1'b0;
		result     = '{code_point: 31'd0, status: utf8d_pkg::ST_OK,
			sequence_length: 3'd1};
		if (state.bytes_pending == 3'd0) begin
			if (b < utf8d_pkg::ASCII_END) begin
				emit              = 1'b1;
				result.code_point = {23'd0, b};
			end else if (b < utf8d_pkg::LEAD_MIN || b >= utf8d_pkg::LEAD_BAD) begin
				emit          = 1'b1;
				result.status = utf8d_pkg::ST_INVALID;
				next_state    = utf8d_pkg::IDLE_STATE;
			end else if (last) begin
				emit          = 1'b1;
				result.status = utf8d_pkg::ST_TRUNCATED;
				next_state    = utf8d_pkg::IDLE_STATE;
			end else begin
				next_state.total_length  = len;
				next_state.bytes_pending = len - 3'd1;
				next_state.lead_byte     = b;
				next_state.partial_value = bits;
			end
		end else begin
			if (bad) begin
				emit                   = 1'b1;
				result.status          = utf8d_pkg::ST_INVALID;
				result.sequence_length = consumed;
				next_state             = utf8d_pkg::IDLE_STATE;
			end else if (new_pending == 3'd0) begin
				emit                   = 1'b1;
				result.code_point      = new_partial;
				result.sequence_length = state.total_length;
				next_state             = utf8d_pkg::IDLE_STATE;
			end else if (last) begin
				emit                   = 1'b1;
				result.status          = utf8d_pkg::ST_TRUNCATED;
				result.sequence_length = consumed;
				next_state             = utf8d_pkg::IDLE_STATE;
			end else begin
				next_state.bytes_pending = new_pending;
				next_state.partial_value = new_partial;
			end
		end
	end

endmodule

// ----- design/utf8_stream_decoder_core.sv -----
// utf8 stream decoder, one- to six-byte forms (code points up to 0x7fffffff)
// input channel: byte_valid / byte_stall / byte_item, one text byte per item
//   with an end-of-text mark; taken at an edge with byte_valid high and
//   byte_stall low
// output channel: result_valid / result_stall / result_item, at most one
//   result per input item (code point, status, sequence length)
// registers: a taken byte sits in the input register, and decode loads its
//   result into the result register once that register has room
// throughput: one byte per cycle unless a stalled result blocks; the decode
//   state is a single register updated by one combinational pass per byte
// stall: while the result register holds an item that the receiver stalls,
//   the byte in the input register waits, and byte_stall rises only when that
//   input register is occupied; bytes that give no result still wait their
//   turn so that order is kept
// reset: arst_n clears both valid flags and the decode state (idle); no
//   item is lost or invented on leaving reset
module utf8_stream_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  utf8d_pkg::in_item_t  byte_item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output utf8d_pkg::out_item_t result_item
);

	// input register
	logic                  valid_s1;
	utf8d_pkg::in_item_t   item_s1;

	// decode state and result register
	utf8d_pkg::dec_state_t state_q;
	utf8d_pkg::dec_state_t next_state;
	logic                  res_valid_q;
	utf8d_pkg::out_item_t  res_item_q;

	logic                  emit;
	utf8d_pkg::out_item_t  result;
	logic                  advance;

	// the held byte moves on once the result register has room
	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	utf8d_decode u_decode (
		.state      (state_q),
		.item       (item_s1),
		.next_state (next_state),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utf8d_pkg::IDLE_STATE;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_item_q <= result;
		end
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_item_q;

endmodule

// ----- tb/sv/tb_utf8_stream_decoder_core.sv -----
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_core;

	// continuation byte range
	localparam logic [7:0] CONT_MIN = 8'h80;
	localparam logic [7:0] CONT_MAX = 8'hbf;

	localparam int TEXT_ITEMS   = 1250;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	// shapes of generated sequences
	typedef enum {SEQ_GOOD, SEQ_OVERLONG, SEQ_CUT, SEQ_BROKEN} seq_kind_t;

	// receiver stall behaviour, swapped now and then
	typedef enum {STALL_NONE, STALL_SOME, STALL_BEAT, STALL_HEAVY} stall_style_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  byte_valid   = 1'b0;
	logic                  byte_stall;
	utf8d_pkg::in_item_t   byte_item    = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	utf8d_pkg::out_item_t  result_item;

	utf8d_pkg::in_item_t   text_bytes[$];       // items still to be sent
	utf8d_pkg::out_item_t  decoded_expected[$]; // results predicted but not yet seen
	// predictor's copy of the decode state
	utf8d_pkg::dec_state_t dec = utf8d_pkg::IDLE_STATE;

	bit           byte_taken;
	bit           result_taken;
	int           stuck_cycles = 0;
	int           mismatches   = 0;
	bit           timed_out    = 1'b0;
	int           burst_left   = 0;
	int           gap_left     = 0;
	stall_style_t stall_style  = STALL_NONE;
	int           style_left   = 0;
	int           beat_count   = 0;

	utf8_stream_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// predicts the result for one accepted text byte, returns 1 when there is one
	function automatic bit decode_byte(input utf8d_pkg::in_item_t it,
		output utf8d_pkg::out_item_t res);
		logic [7:0]  b;
		logic [2:0]  used;
		logic [2:0]  n;
		logic [30:0] lead_bits;
		bit          bad;
		b   = it.byte_value;
		res = '0;
		res.status = utf8d_pkg::ST_OK;
		if (dec.bytes_pending == 3'd0) begin
			res.sequence_length = 3'd1;
			// plain ascii comes straight through
			if (b < utf8d_pkg::ASCII_END) begin
				res.code_point = {23'd0, b};
				return 1'b1;
			end
			// stray continuation, overlong two-byte lead, or never-valid byte
			if (b < utf8d_pkg::LEAD_MIN || b >= utf8d_pkg::LEAD_BAD) begin
				dec = utf8d_pkg::IDLE_STATE;
				res.status = utf8d_pkg::ST_INVALID;
				return 1'b1;
			end
			if (b < utf8d_pkg::LEAD_3B) begin
				n = 3'd2;
				lead_bits = {26'd0, b[4:0]};
			end else if (b < utf8d_pkg::LEAD_4B) begin
				n = 3'd3;
				lead_bits = {27'd0, b[3:0]};
			end else if (b < utf8d_pkg::LEAD_5B) begin
				n = 3'd4;
				lead_bits = {28'd0, b[2:0]};
			end else if (b < utf8d_pkg::LEAD_6B) begin
				n = 3'd5;
				lead_bits = {29'd0, b[1:0]};
			end else begin
				n = 3'd6;
				lead_bits = {30'd0, b[0]};
			end
			// text ends right on a lead byte
			if (it.end_of_text) begin
				dec = utf8d_pkg::IDLE_STATE;
				res.status = utf8d_pkg::ST_TRUNCATED;
				return 1'b1;
			end
			dec.total_length  = n;
			dec.bytes_pending = n - 3'd1;
			dec.lead_byte     = b;
			dec.partial_value = lead_bits;
			return 1'b0;
		end

		used = dec.total_length - dec.bytes_pending + 3'd1;
		bad  = (b[7:6] != 2'b10);
		// overlong forms are caught on the second byte
		if (!bad && dec.bytes_pending + 3'd1 == dec.total_length) begin
			case (dec.total_length)
			3'd3: bad = (dec.lead_byte < utf8d_pkg::OVL_LEAD_3) && (b < utf8d_pkg::OVL_MIN_3);
			3'd4: bad = (dec.lead_byte < utf8d_pkg::OVL_LEAD_4) && (b < utf8d_pkg::OVL_MIN_4);
			3'd5: bad = (dec.lead_byte < utf8d_pkg::OVL_LEAD_5) && (b < utf8d_pkg::OVL_MIN_5);
			3'd6: bad = (dec.lead_byte < utf8d_pkg::OVL_LEAD_6) && (b < utf8d_pkg::OVL_MIN_6);
			default: ;
			endcase
		end
		// an error wins over truncation on the same byte
		if (bad) begin
			dec = utf8d_pkg::IDLE_STATE;
			res.status = utf8d_pkg::ST_INVALID;
			res.sequence_length = used;
			return 1'b1;
		end
		dec.partial_value = {dec.partial_value[24:0], b[5:0]};
		dec.bytes_pending = dec.bytes_pending - 3'd1;
		if (dec.bytes_pending == 3'd0) begin
			res.code_point = dec.partial_value;
			res.sequence_length = dec.total_length;
			dec = utf8d_pkg::IDLE_STATE;
			return 1'b1;
		end
		if (it.end_of_text) begin
			dec = utf8d_pkg::IDLE_STATE;
			res.status = utf8d_pkg::ST_TRUNCATED;
			res.sequence_length = used;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit eot);
		utf8d_pkg::in_item_t it;
		it.byte_value  = b;
		it.end_of_text = eot;
		text_bytes.push_back(it);
	endtask

	// one sequence of n bytes, intact or spoilt as the kind says
	task automatic queue_sequence(input int n, input seq_kind_t kind);
		logic [7:0] lead_lo;
		logic [7:0] lead_hi;
		logic [7:0] lead;
		logic [7:0] lo2;
		logic [7:0] b;
		int         last;
		int         spoilt;
		bit         eot;
		case (n)
		1: begin lead_lo = 8'h00; lead_hi = utf8d_pkg::ASCII_END - 8'd1; end
		2: begin lead_lo = utf8d_pkg::LEAD_MIN; lead_hi = utf8d_pkg::LEAD_3B - 8'd1; end
		3: begin lead_lo = utf8d_pkg::LEAD_3B; lead_hi = utf8d_pkg::LEAD_4B - 8'd1; end
		4: begin lead_lo = utf8d_pkg::LEAD_4B; lead_hi = utf8d_pkg::LEAD_5B - 8'd1; end
		5: begin lead_lo = utf8d_pkg::LEAD_5B; lead_hi = utf8d_pkg::LEAD_6B - 8'd1; end
		default: begin lead_lo = utf8d_pkg::LEAD_6B; lead_hi = utf8d_pkg::LEAD_BAD - 8'd1; end
		endcase
		lead = (kind == SEQ_OVERLONG) ? lead_lo : 8'($urandom_range(lead_lo, lead_hi));
		// smallest legal second byte for this lead
		case (n)
		3: lo2 = (lead < utf8d_pkg::OVL_LEAD_3) ? utf8d_pkg::OVL_MIN_3 : CONT_MIN;
		4: lo2 = (lead < utf8d_pkg::OVL_LEAD_4) ? utf8d_pkg::OVL_MIN_4 : CONT_MIN;
		5: lo2 = (lead < utf8d_pkg::OVL_LEAD_5) ? utf8d_pkg::OVL_MIN_5 : CONT_MIN;
		6: lo2 = (lead < utf8d_pkg::OVL_LEAD_6) ? utf8d_pkg::OVL_MIN_6 : CONT_MIN;
		default: lo2 = CONT_MIN;
		endcase
		last   = n - 1;
		spoilt = n;
		case (kind)
		SEQ_CUT: last = $urandom_range(0, n - 2);
		SEQ_BROKEN: begin
			spoilt = $urandom_range(1, n - 1);
			last   = spoilt;
		end
		SEQ_OVERLONG: begin
			spoilt = 1;
			last   = 1;
		end
		default: ;
		endcase
		for (int i = 0; i <= last; i++) begin
			if (i == 0)
				b = lead;
			else if (i == spoilt && kind == SEQ_OVERLONG)
				b = 8'($urandom_range(CONT_MIN, lo2 - 8'd1));
			else if (i == spoilt)
				b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h00, 8'h7f))
					: 8'($urandom_range(8'hc0, 8'hff));
			else if (i == 1)
				b = ($urandom_range(0, 3) == 0) ? lo2 : 8'($urandom_range(lo2, CONT_MAX));
			else
				b = 8'($urandom_range(CONT_MIN, CONT_MAX));
			eot = (i == last) && (kind == SEQ_CUT || $urandom_range(0, 15) == 0);
			queue_byte(b, eot);
		end
	endtask

	// sender: bursts of items with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (arst_n && (!byte_valid || byte_taken)) begin
			if (gap_left > 0) begin
				byte_valid <= 1'b0;
				gap_left--;
			end else if (text_bytes.size() > 0) begin
				byte_item  <= text_bytes.pop_front();
				byte_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// receiver: drives result_stall by a stall style that is drawn anew at random
	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left  = $urandom_range(64, 256);
		end else begin
			style_left--;
		end
		beat_count++;
		case (stall_style)
		STALL_NONE:  result_stall <= 1'b0;
		STALL_SOME:  result_stall <= ($urandom_range(0, 2) == 0);
		STALL_BEAT:  result_stall <= ((beat_count % 5) < 2);
		STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
		default:     result_stall <= 1'b0;
		endcase
	end

	// monitor: predict on each accepted byte, check each accepted result
	always @(posedge clk) begin
		utf8d_pkg::out_item_t want;
		utf8d_pkg::out_item_t got;
		byte_taken   = arst_n && byte_valid && !byte_stall;
		result_taken = arst_n && result_valid && !result_stall;
		if (byte_taken) begin
			if (decode_byte(byte_item, want))
				decoded_expected.push_back(want);
		end
		if (result_taken) begin
			got = result_item;
			if (decoded_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result cp %h status %0d len %0d",
					got.code_point, got.status, got.sequence_length));
			end else begin
				want = decoded_expected.pop_front();
				if (got.code_point !== want.code_point)
					report_mismatch($sformatf("code_point got %h want %h",
						got.code_point, want.code_point));
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got.status, want.status));
				if (got.sequence_length !== want.sequence_length)
					report_mismatch($sformatf("sequence_length got %0d want %0d",
						got.sequence_length, want.sequence_length));
			end
		end
		// watchdog: cycles in which neither side moves an item
		stuck_cycles = (!arst_n || byte_taken || result_taken) ? 0 : stuck_cycles + 1;
	end

	initial begin
		int pick;

		// opening text: ascii extremes, a stray continuation and bad leads
		queue_byte(8'h00, 1'b0); queue_byte(8'h7f, 1'b0);
		queue_byte(8'h80, 1'b0); queue_byte(8'hc1, 1'b0);
		queue_byte(8'hfe, 1'b0); queue_byte(8'hff, 1'b0);
		// largest six-byte value
		queue_byte(8'hfd, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_byte(8'hbf, 1'b0);
		// overlong three-byte form
		queue_byte(8'he0, 1'b0); queue_byte(8'h9f, 1'b0);
		// bad continuation, the ascii byte is swallowed
		queue_byte(8'hc3, 1'b0); queue_byte(8'h41, 1'b0);
		// text ends on a lead
		queue_byte(8'hf0, 1'b1);
		// high surrogate passes through
		queue_byte(8'hed, 1'b0); queue_byte(8'ha0, 1'b0); queue_byte(8'h80, 1'b0);
		// text ends inside a sequence
		queue_byte(8'he1, 1'b0); queue_byte(8'h80, 1'b1);
		// error on the last byte beats truncation
		queue_byte(8'he2, 1'b0); queue_byte(8'hc0, 1'b1);

		// mostly well-formed sequences, the rest spoilt or plain noise
		while (text_bytes.size() < TEXT_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				queue_sequence($urandom_range(1, 6), SEQ_GOOD);
			else if (pick < 65)
				queue_sequence($urandom_range(3, 6), SEQ_OVERLONG);
			else if (pick < 77)
				queue_sequence($urandom_range(2, 6), SEQ_CUT);
			else if (pick < 89)
				queue_sequence($urandom_range(2, 6), SEQ_BROKEN);
			else
				queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fork
			begin
				// every item sent, every result seen, then let the pipe drain
				while (text_bytes.size() > 0 || byte_valid)
					@(posedge clk);
				while (decoded_expected.size() > 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			begin
				while (stuck_cycles < STUCK_LIMIT)
					@(posedge clk);
				timed_out = 1'b1;
			end
		join_any

		if (!timed_out && mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/utf8d_pkg.sv
design/utf8d_decode.sv
design/utf8_stream_decoder_core.sv
tb/sv/tb_utf8_stream_decoder_core.sv
